/* src/lzsr_pkg.sv */
// Package for the longest zero-sum run block: sizes, channel payloads and the cell token.
package lzsr_pkg;

   // Array length limit and sample width.
   localparam int MAX_ITEMS   = 1024;
   localparam int SAMPLE_BITS = 16;

   // Derived widths: a position within the array, a count up to the limit, the prefix sum.
   localparam int POS_BITS  = $clog2(MAX_ITEMS);
   localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + POS_BITS;
   localparam int BEST_BITS = 11;

   // Input item.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [BEST_BITS-1:0] best_length;
      logic                 final_res;
      logic                 overflow;
   } rsp_type;

   // Token that travels down the row of cells, one cell per cycle while the row advances.
   typedef struct packed {
      logic                valid;  // a sample occupies this stage
      logic                take;   // sample was accepted into the array (not beyond the limit)
      logic                live;   // its own table slot is still to be written
      logic                probe;  // still looking for an earlier equal prefix sum
      logic                zero;   // prefix sum is zero
      logic                found;  // an earlier equal prefix sum was found
      logic                last;   // sample closes the array
      logic                ovf;    // the array has gone beyond the limit
      logic [POS_BITS-1:0] rem;    // cells left before its own slot
      logic [POS_BITS-1:0] idx;    // position of the sample in the array
      logic [SUM_BITS-1:0] key;    // prefix sum after this sample
      logic [POS_BITS-1:0] run;    // run length from the matching entry
   } token_type;

endpackage

/* src/lzsr_front.sv */
// Front stage: running prefix sum, sample position and limit tracking; issues tokens.
module lzsr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                req_valid,
   input  lzsr_pkg::req_type   req_data,
   output lzsr_pkg::token_type tok_out
);

   logic signed [lzsr_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [lzsr_pkg::CNT_BITS-1:0]        pos_ff, pos_in;
   logic                                 ovf_ff, ovf_in;
   lzsr_pkg::token_type                  tok_ff, tok_in;
   logic                                 accept;
   logic                                 skip;
   logic signed [lzsr_pkg::SUM_BITS-1:0] sample_ext;
   logic signed [lzsr_pkg::SUM_BITS-1:0] new_sum;

   assign accept     = req_valid && adv;
   assign skip       = (pos_ff == lzsr_pkg::CNT_BITS'(lzsr_pkg::MAX_ITEMS));
   assign sample_ext = {{(lzsr_pkg::SUM_BITS - lzsr_pkg::SAMPLE_BITS)
                        {req_data.sample[lzsr_pkg::SAMPLE_BITS-1]}}, req_data.sample};
   assign new_sum    = sum_ff + sample_ext;

   // Build the token and the next array state for a transfer on the input channel.
   always_comb begin
      sum_in = sum_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      tok_in = '0;
      if (accept) begin
         tok_in.valid = 1'b1;
         tok_in.take  = !skip;
         tok_in.live  = !skip;
         tok_in.probe = !skip && (new_sum != '0);
         tok_in.zero  = !skip && (new_sum == '0);
         tok_in.last  = req_data.last;
         tok_in.ovf   = skip || ovf_ff;
         tok_in.idx   = pos_ff[lzsr_pkg::POS_BITS-1:0];
         tok_in.rem   = pos_ff[lzsr_pkg::POS_BITS-1:0];
         tok_in.key   = new_sum;
         if (req_data.last) begin
            sum_in = '0;
            pos_in = '0;
            ovf_in = 1'b0;
         end else if (!skip) begin
            sum_in = new_sum;
            pos_in = pos_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // State and token registers; the token register holds while the row is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         pos_ff <= '0;
         ovf_ff <= 1'b0;
         tok_ff <= '0;
      end else if (adv) begin
         sum_ff <= sum_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
         tok_ff <= tok_in;
      end
   end

   assign tok_out = tok_ff;

`ifndef SYNTH
   // Samples are only ever ignored once the array has reached the limit.
   a_ovf_at_limit: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> pos_ff == lzsr_pkg::CNT_BITS'(lzsr_pkg::MAX_ITEMS))
      else $error("overflow set below the array limit");

   // Closing an array leaves the sum and position cleared.
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last |=> pos_ff == '0 && sum_ff == '0 && !ovf_ff)
      else $error("array state not cleared after the last sample");
`endif

endmodule

/* src/lzsr_cell.sv */
// One table cell: holds the prefix sum of one array position and checks passing tokens.
module lzsr_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  lzsr_pkg::token_type tok_in,
   output lzsr_pkg::token_type tok_out
);

   logic [lzsr_pkg::SUM_BITS-1:0] key_ff;
   logic [lzsr_pkg::POS_BITS-1:0] pos_ff;
   logic                          write;
   lzsr_pkg::token_type           out_ff, out_in;

   // The token claims this cell when no earlier cells remain before its own slot.
   assign write = tok_in.valid && tok_in.live && (tok_in.rem == '0);

   // Cells before the slot are compared; the first equal sum gives the run.
   always_comb begin
      out_in = tok_in;
      if (tok_in.valid && tok_in.live) begin
         if (tok_in.rem == '0) begin
            out_in.live  = 1'b0;
            out_in.probe = 1'b0;
         end else begin
            out_in.rem = tok_in.rem - 1'b1;
            if (tok_in.probe && (key_ff == tok_in.key)) begin
               out_in.found = 1'b1;
               out_in.probe = 1'b0;
               out_in.run   = tok_in.idx - pos_ff;
            end
         end
      end
   end

   // Stored entry; written only by the token whose slot this is.
   always_ff @(posedge clock) begin
      if (adv && write) begin
         key_ff <= tok_in.key;
         pos_ff <= tok_in.idx;
      end
   end

   // Hand the token on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign tok_out = out_ff;

endmodule

/* src/lzsr_tail.sv */
// Tail stage: keeps the longest run of the array and holds the result register.
module lzsr_tail (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  lzsr_pkg::token_type tok_in,
   output logic                rsp_valid,
   output lzsr_pkg::rsp_type   rsp_data
);

   logic [lzsr_pkg::CNT_BITS-1:0] longest_ff, longest_in;
   logic [lzsr_pkg::CNT_BITS-1:0] best;
   logic [lzsr_pkg::CNT_BITS-1:0] run_ext;
   logic                          valid_ff, valid_in;
   lzsr_pkg::rsp_type             rsp_ff, rsp_in;

   assign run_ext = lzsr_pkg::CNT_BITS'(tok_in.run);

   // Update the best run: a zero sum runs from the start, a match from its first sighting.
   always_comb begin
      best = longest_ff;
      if (tok_in.take) begin
         if (tok_in.zero) begin
            best = lzsr_pkg::CNT_BITS'(tok_in.idx) + 1'b1;
         end else if (tok_in.found && (run_ext > longest_ff)) begin
            best = run_ext;
         end
      end
      longest_in              = longest_ff;
      valid_in                = tok_in.valid;
      rsp_in                  = rsp_ff;
      if (tok_in.valid) begin
         longest_in           = tok_in.last ? '0 : best;
         rsp_in.best_length   = lzsr_pkg::BEST_BITS'(best);
         rsp_in.final_res     = tok_in.last;
         rsp_in.overflow      = tok_in.ovf;
      end
   end

   // Result register; it holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         longest_ff <= '0;
         valid_ff   <= 1'b0;
         rsp_ff     <= '0;
      end else if (adv) begin
         longest_ff <= longest_in;
         valid_ff   <= valid_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // Every token leaving the row has written its slot and finished its search.
   a_token_done: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid |-> !tok_in.live && !tok_in.probe)
      else $error("token left the row with work outstanding");

   // A match only happens for an accepted sample with a nonzero sum, and is never empty.
   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid && tok_in.found |-> tok_in.take && !tok_in.zero && tok_in.run != '0)
      else $error("inconsistent match in token");

   // The best run never exceeds the array limit.
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> longest_ff <= lzsr_pkg::CNT_BITS'(lzsr_pkg::MAX_ITEMS))
      else $error("longest run beyond the array limit");
`endif

endmodule

/* src/longest_zero_sum_run_top.sv */
// Top level of the longest zero-sum run block: front stage, row of cells and tail stage.
//
// Usage: samples of an array arrive on the req_ channel, one per transfer, with last
// set on the final sample. Each sample gives exactly one result on the rsp_ channel:
// the longest zero-sum contiguous run so far in the array, final_res (a copy of last)
// and overflow once samples beyond MAX_ITEMS have been ignored.
// On its way to the result, a sample passes the front register, which loads at the
// transfer itself, then one registered table cell per array position (each cell holds
// the prefix sum of one array position) and finally the result register.
// Throughput is one sample per cycle unless the receiver stalls; the row of cells
// is a pipeline and a new array may follow the last sample of the previous one at once.
// When the receiver stalls, the whole row holds and req_ready drops; it rises again as
// soon as the waiting result is transferred.
// Reset clears the sum, position, best run and all tokens in flight; table contents
// need no clearing, since a sample only consults cells written earlier in its array.
module longest_zero_sum_run_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzsr_pkg::rsp_type rsp_data
);

   lzsr_pkg::token_type tok [0:lzsr_pkg::MAX_ITEMS];
   logic                adv;

   // The row advances whenever the result register is free or being emptied.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   lzsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .tok_out   (tok[0])
   );

   // One cell per array position.
   for (genvar g = 0; g < lzsr_pkg::MAX_ITEMS; g++) begin : g_cell
      lzsr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   lzsr_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .tok_in    (tok[lzsr_pkg::MAX_ITEMS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
